[design/assert_macros.svh]
// Assertion macros shared by the scheduler RTL.
// Each macro expects signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pts_pkg.sv]
// Types and constants for the periodic tick task scheduler.
// Used by pts_slot and periodic_task_tick_scheduler_top; depends on nothing.
package pts_pkg;

    localparam int DATA_W = 16;
    localparam int SLOT_W = 3;
    localparam int MASK_W = 8;

    localparam logic MODE_TICK     = 1'b0;
    localparam logic MODE_REGISTER = 1'b1;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_TAKEN = 1'b1;

    typedef logic [DATA_W-1:0] data_t;
    typedef logic [SLOT_W-1:0] slot_t;
    typedef logic [MASK_W-1:0] mask_t;

    localparam data_t DATA_ONE  = data_t'(1);
    localparam data_t DATA_ZERO = data_t'(0);

    // Command from the execute stage to one slot.
    typedef struct packed {
        logic  tick;
        logic  load;
        data_t period;
        data_t first_delay;
    } slot_cmd_t;

    // State seen by the execute stage; fire_due means it fires on a tick.
    typedef struct packed {
        logic occupied;
        logic pending;
        logic fire_due;
    } slot_stat_t;

endpackage

[design/pts_slot.sv]
// One task slot: occupied bit, period, countdown and sticky pending flag.
// Depends on pts_pkg for the command and status structs.
module pts_slot (
    input  logic               clk,
    input  logic               rst_n,
    input  pts_pkg::slot_cmd_t cmd,
    output pts_pkg::slot_stat_t stat
);

    logic           occupied_reg;
    logic           occupied_next;
    logic           pending_reg;
    logic           pending_next;
    pts_pkg::data_t period_reg;
    pts_pkg::data_t period_next;
    pts_pkg::data_t countdown_reg;
    pts_pkg::data_t countdown_next;
    logic           zero_count;

    assign zero_count = (countdown_reg == pts_pkg::DATA_ZERO);

    always_comb
    begin
        occupied_next  = occupied_reg;
        pending_next   = pending_reg;
        period_next    = period_reg;
        countdown_next = countdown_reg;
        if (cmd.load)
        begin
            occupied_next  = 1'b1;
            period_next    = cmd.period;
            countdown_next = cmd.first_delay;
        end
        else if (cmd.tick && occupied_reg)
        begin
            if (zero_count)
            begin
                // Reload wraps to all ones when the period is zero.
                countdown_next = period_reg - pts_pkg::DATA_ONE;
                pending_next   = 1'b1;
            end
            else
            begin
                countdown_next = countdown_reg - pts_pkg::DATA_ONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occupied_reg <= 1'b0;
            pending_reg  <= 1'b0;
        end
        else
        begin
            occupied_reg <= occupied_next;
            pending_reg  <= pending_next;
        end
    end

    // Period and countdown are only read while the slot is occupied.
    always_ff @(posedge clk)
    begin
        period_reg    <= period_next;
        countdown_reg <= countdown_next;
    end

    assign stat.occupied = occupied_reg;
    assign stat.pending  = pending_reg;
    assign stat.fire_due = occupied_reg && zero_count;

endmodule

[design/periodic_task_tick_scheduler_top.sv]
// Top level of the periodic tick task scheduler: input register, execute stage
// over a bank of pts_slot cells, and result register. Depends on pts_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  in      | in_valid / in_ready | mode, slot, period, first_delay, handler_valid
//  out     | out_valid/out_ready | status, fired_mask, pending_mask
//
// One request per cycle sustained while out_ready is high; a request is taken into
// the input register, then the slot bank updates its result into the result register.
// All slots are updated in parallel in the execute stage.
// Reset frees every slot and clears all pending flags at once.
// While out_ready is low the result holds and one more request waits in the
// input register before in_ready drops.
module periodic_task_tick_scheduler_top #(
    parameter int TASK_SLOTS = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   mode,
    input  pts_pkg::slot_t         slot,
    input  pts_pkg::data_t         period,
    input  pts_pkg::data_t         first_delay,
    input  logic                   handler_valid,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   status,
    output pts_pkg::mask_t         fired_mask,
    output pts_pkg::mask_t         pending_mask
);

    `include "assert_macros.svh"

    // Input register.
    logic           in_valid_reg;
    logic           mode_reg;
    pts_pkg::slot_t slot_reg;
    pts_pkg::data_t period_reg;
    pts_pkg::data_t first_delay_reg;
    logic           handler_valid_reg;

    // Result register.
    logic           out_valid_reg;
    logic           status_reg;
    logic           status_next;
    pts_pkg::mask_t fired_mask_reg;
    pts_pkg::mask_t fired_mask_next;
    pts_pkg::mask_t pending_mask_reg;
    pts_pkg::mask_t pending_mask_next;

    logic           exec;
    logic           do_tick;
    logic           do_load;
    pts_pkg::mask_t taken_vec;
    logic [TASK_SLOTS-1:0] pend_vec;

    pts_pkg::slot_cmd_t  cmd [TASK_SLOTS];
    pts_pkg::slot_stat_t stat [TASK_SLOTS];

    assign exec     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || exec;
    assign do_tick  = exec && (mode_reg == pts_pkg::MODE_TICK);

    // Slots outside the bank count as taken so a request to them is rejected.
    assign status_next = (mode_reg == pts_pkg::MODE_REGISTER) ? taken_vec[slot_reg]
                                                              : pts_pkg::STATUS_OK;
    assign do_load = exec && (mode_reg == pts_pkg::MODE_REGISTER)
                     && (status_next == pts_pkg::STATUS_OK) && handler_valid_reg;

    genvar gi;
    generate
        for (gi = 0; gi < TASK_SLOTS; gi++)
        begin : g_slot
            assign cmd[gi].tick        = do_tick;
            assign cmd[gi].period      = period_reg;
            assign cmd[gi].first_delay = first_delay_reg;
            if (gi < pts_pkg::MASK_W)
            begin : g_addr
                assign cmd[gi].load = do_load && (slot_reg == pts_pkg::slot_t'(gi));
            end
            else
            begin : g_noaddr
                assign cmd[gi].load = 1'b0;
            end

            assign pend_vec[gi] = stat[gi].pending;

            pts_slot u_slot (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd[gi]),
                .stat  (stat[gi])
            );
        end

        for (gi = 0; gi < pts_pkg::MASK_W; gi++)
        begin : g_mask
            if (gi < TASK_SLOTS)
            begin : g_present
                assign taken_vec[gi]         = stat[gi].occupied;
                assign fired_mask_next[gi]   = (mode_reg == pts_pkg::MODE_TICK)
                                               && stat[gi].fire_due;
                assign pending_mask_next[gi] = stat[gi].pending || fired_mask_next[gi];
            end
            else
            begin : g_absent
                assign taken_vec[gi]         = 1'b1;
                assign fired_mask_next[gi]   = 1'b0;
                assign pending_mask_next[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (exec)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            mode_reg          <= mode;
            slot_reg          <= slot;
            period_reg        <= period;
            first_delay_reg   <= first_delay;
            handler_valid_reg <= handler_valid;
        end
        if (exec)
        begin
            status_reg       <= status_next;
            fired_mask_reg   <= fired_mask_next;
            pending_mask_reg <= pending_mask_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign fired_mask   = fired_mask_reg;
    assign pending_mask = pending_mask_reg;

    `PTS_ASSERT(a_fired_is_pending,
        out_valid_reg |-> ((fired_mask_reg & ~pending_mask_reg) == '0),
        "fired slot not flagged pending")
    `PTS_ASSERT(a_reject_no_fire,
        (out_valid_reg && status_reg) |-> (fired_mask_reg == '0),
        "rejected request reports a firing")
    `PTS_ASSERT(a_pending_sticky,
        1'b1 |=> (($past(pend_vec) & ~pend_vec) == '0),
        "pending flag was cleared")
    // The pipeline is seen empty at the edge after any edge with reset low.
    `PTS_ASSERT_ALWAYS(a_reset_empty,
        !rst_n |=> (!out_valid_reg && !in_valid_reg),
        "pipeline not empty in reset")

endmodule
